### sv/grta_pkg.sv
// Types and constants shared by the RMC time acquisition block.
// No dependencies; compiled first.
`default_nettype none

package grta_pkg;

  // Field widths
  localparam int unsigned MS_W      = 20;
  localparam int unsigned WIN_W     = 16;
  localparam int unsigned TRIAL_W   = 4;
  localparam int unsigned FIELD_W   = 4;
  localparam int unsigned POS_W     = 8;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned YEAR_W    = 12;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned NUM_TD    = 6;

  // Acquisition states, also the status code of a result item
  typedef enum logic [1:0] {
    ACQ_GET_TIME  = 2'd0,
    ACQ_WAIT_PPS  = 2'd1,
    ACQ_AVAILABLE = 2'd2,
    ACQ_NO_TIME   = 2'd3
  } acq_state_e;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PPS_WINDOW = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PPS_TRIALS = 2'd2;

  // Configuration reset values
  localparam logic [MS_W-1:0]    RST_TIME_LIMIT = 20'd120000;
  localparam logic [WIN_W-1:0]   RST_PPS_WINDOW = 16'd1000;
  localparam logic [TRIAL_W-1:0] RST_PPS_TRIALS = 4'd10;

  // Timer and byte position saturation values
  localparam logic [MS_W-1:0] ELAPSED_MAX = {MS_W{1'b1}};
  localparam logic [POS_W-1:0] POS_MAX    = {POS_W{1'b1}};

  // NMEA characters
  localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
  localparam logic [BYTE_W-1:0] CH_R      = 8'h52;
  localparam logic [BYTE_W-1:0] CH_M      = 8'h4D;
  localparam logic [BYTE_W-1:0] CH_C      = 8'h43;
  localparam logic [BYTE_W-1:0] CH_COMMA  = 8'h2C;
  localparam logic [BYTE_W-1:0] CH_A      = 8'h41;
  localparam logic [BYTE_W-1:0] CH_ZERO   = 8'h30;

  // Byte positions inside the sentence type, status field and digit groups
  localparam logic [POS_W-1:0] POS_TYPE_R   = 8'd3;
  localparam logic [POS_W-1:0] POS_TYPE_M   = 8'd4;
  localparam logic [POS_W-1:0] POS_TYPE_C   = 8'd5;
  localparam logic [POS_W-1:0] POS_STATUS   = 8'd1;
  localparam logic [POS_W-1:0] POS_DIG_LAST = 8'd6;

  // Field states of the sentence parser
  localparam logic [FIELD_W-1:0] FS_TYPE       = 4'd0;
  localparam logic [FIELD_W-1:0] FS_SEP        = 4'd1;
  localparam logic [FIELD_W-1:0] FS_TIME       = 4'd2;
  localparam logic [FIELD_W-1:0] FS_SKIP_TIME  = 4'd3;
  localparam logic [FIELD_W-1:0] FS_STATUS     = 4'd4;
  localparam logic [FIELD_W-1:0] FS_SKIP_FIRST = 4'd5;
  localparam logic [FIELD_W-1:0] FS_SKIP_LAST  = 4'd10;
  localparam logic [FIELD_W-1:0] FS_DATE       = 4'd11;

  // Slots of the time and date fields
  localparam int unsigned TD_TIME_BASE = 0;
  localparam int unsigned TD_DATE_BASE = 3;

  localparam logic [YEAR_W-1:0] YEAR_BASE = 12'd2000;
  localparam logic [YEAR_W-1:0] YEAR_LAST = 12'd2255;

  typedef struct packed {
    logic              op;
    logic              byte_valid;
    logic [BYTE_W-1:0] rx_byte;
    logic              pps_level;
    logic              ms_tick;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        acq_status;
    logic              rcv_enable;
    logic [BYTE_W-1:0] hour;
    logic [BYTE_W-1:0] minute;
    logic [BYTE_W-1:0] second;
    logic [BYTE_W-1:0] day;
    logic [BYTE_W-1:0] month;
    logic [YEAR_W-1:0] year;
  } result_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [MS_W-1:0]      value;
  } cfg_write_t;

  // Register values as seen by the core
  typedef struct packed {
    logic [MS_W-1:0]    time_limit_ms;
    logic [WIN_W-1:0]   pps_window_ms;
    logic [TRIAL_W-1:0] pps_max_trials;
  } cfg_t;

endpackage

`default_nettype wire

### sv/grta_chan_if.sv
// Valid/ready channel carrying one payload item.
// Payload type is supplied by the user, normally a struct from grta_pkg.
`default_nettype none

interface grta_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

### sv/grta_cfg_regs.sv
// Configuration registers of the RMC time acquisition block.
// Depends on grta_pkg and grta_chan_if.
`default_nettype none

module grta_cfg_regs (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  grta_chan_if.sink         cfg_i,
  output grta_pkg::cfg_t    cfg_o
);

  grta_pkg::cfg_t cfg_q, cfg_d;

  // Always take a write; indexes beyond the list are dropped
  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (cfg_i.payload.index)
        grta_pkg::CFG_TIME_LIMIT: cfg_d.time_limit_ms = cfg_i.payload.value;
        grta_pkg::CFG_PPS_WINDOW:
          cfg_d.pps_window_ms = cfg_i.payload.value[grta_pkg::WIN_W-1:0];
        grta_pkg::CFG_PPS_TRIALS:
          cfg_d.pps_max_trials = cfg_i.payload.value[grta_pkg::TRIAL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.time_limit_ms  <= grta_pkg::RST_TIME_LIMIT;
      cfg_q.pps_window_ms  <= grta_pkg::RST_PPS_WINDOW;
      cfg_q.pps_max_trials <= grta_pkg::RST_PPS_TRIALS;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

### sv/grta_core.sv
// Acquisition state, sentence parser and time/date fields.
// One step per accepted item; depends on grta_pkg.
`default_nettype none

module grta_core (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              step_i,
  input  grta_pkg::in_item_t     item_i,
  input  grta_pkg::cfg_t         cfg_i,
  output grta_pkg::result_t      result_o
);

  grta_pkg::acq_state_e                state_q, state_d;
  logic [grta_pkg::MS_W-1:0]           elapsed_q, elapsed_d;
  logic [grta_pkg::TRIAL_W-1:0]        trials_q, trials_d;
  logic                                pps_q, pps_d;
  logic                                active_q, active_d;
  logic                                rmc_q, rmc_d;
  logic [grta_pkg::FIELD_W-1:0]        field_q, field_d;
  logic [grta_pkg::POS_W-1:0]          pos_q, pos_d;
  logic                                enable_q, enable_d;
  logic [grta_pkg::BYTE_W-1:0]         td_q [grta_pkg::NUM_TD];
  logic [grta_pkg::BYTE_W-1:0]         td_d [grta_pkg::NUM_TD];

  logic [grta_pkg::MS_W-1:0]           elapsed_inc;
  logic [grta_pkg::POS_W-1:0]          pos_inc;
  logic [grta_pkg::BYTE_W-1:0]         digit;
  logic [grta_pkg::BYTE_W-1:0]         digit_x10;
  logic                                dig_pos_ok;
  logic [1:0]                          dig_slot;
  logic                                date_done;
  logic [grta_pkg::TRIAL_W:0]          trial_next;
  logic                                b_valid;
  logic [grta_pkg::BYTE_W-1:0]         b;

  assign b_valid = item_i.byte_valid;
  assign b       = item_i.rx_byte;

  // Shared per-item terms: position after this byte, its digit value, next elapsed time and trial count
  always_comb begin
    pos_inc    = (pos_q != grta_pkg::POS_MAX) ? pos_q + 1'b1 : pos_q;
    digit      = b - grta_pkg::CH_ZERO;
    digit_x10  = {digit[4:0], 3'b000} + {digit[6:0], 1'b0};
    dig_pos_ok = (pos_inc != '0) && (pos_inc <= grta_pkg::POS_DIG_LAST);
    dig_slot   = 2'((pos_inc - 1'b1) >> 1);
    elapsed_inc = (item_i.ms_tick && elapsed_q != grta_pkg::ELAPSED_MAX) ?
                  elapsed_q + 1'b1 : elapsed_q;
    trial_next = {1'b0, trials_q} + 1'b1;
  end

  // Next state of one step
  always_comb begin
    state_d   = state_q;
    elapsed_d = elapsed_q;
    trials_d  = trials_q;
    pps_d     = pps_q;
    active_d  = active_q;
    rmc_d     = rmc_q;
    field_d   = field_q;
    pos_d     = pos_q;
    enable_d  = enable_q;
    td_d      = td_q;
    date_done = 1'b0;

    if (item_i.op) begin
      // Restart acquisition and power the receiver
      state_d   = grta_pkg::ACQ_GET_TIME;
      active_d  = 1'b0;
      enable_d  = 1'b1;
      trials_d  = '0;
      elapsed_d = '0;
    end else begin
      elapsed_d = elapsed_inc;
      case (state_q)
        grta_pkg::ACQ_GET_TIME: begin
          if (elapsed_inc > cfg_i.time_limit_ms) begin
            state_d   = grta_pkg::ACQ_NO_TIME;
            elapsed_d = '0;
            enable_d  = 1'b0;
          end else begin
            if (active_q) begin
              if (b_valid) begin
                pos_d = pos_inc;
                case (field_q)
                  // Sentence type after the talker id
                  grta_pkg::FS_TYPE: begin
                    if (pos_inc == grta_pkg::POS_TYPE_R) begin
                      rmc_d = (b == grta_pkg::CH_R);
                    end else if (pos_inc == grta_pkg::POS_TYPE_M) begin
                      rmc_d = rmc_q && (b == grta_pkg::CH_M);
                    end else if (pos_inc == grta_pkg::POS_TYPE_C) begin
                      rmc_d    = rmc_q && (b == grta_pkg::CH_C);
                      active_d = rmc_d;
                      if (rmc_d) field_d = grta_pkg::FS_SEP;
                    end
                  end
                  grta_pkg::FS_SEP: begin
                    if (b == grta_pkg::CH_COMMA) begin
                      field_d = grta_pkg::FS_TIME;
                      pos_d   = '0;
                    end else begin
                      field_d  = grta_pkg::FS_TYPE;
                      active_d = 1'b0;
                    end
                  end
                  // hhmmss
                  grta_pkg::FS_TIME: begin
                    if (dig_pos_ok) begin
                      for (int i = 0; i < 3; i++) begin
                        if (dig_slot == 2'(i)) begin
                          td_d[grta_pkg::TD_TIME_BASE+i] = pos_inc[0] ? digit_x10 :
                              td_q[grta_pkg::TD_TIME_BASE+i] + digit;
                        end
                      end
                    end
                    if (pos_inc == grta_pkg::POS_DIG_LAST) begin
                      field_d = grta_pkg::FS_SKIP_TIME;
                      pos_d   = '0;
                    end
                  end
                  // Status: anything but A drops the sentence
                  grta_pkg::FS_STATUS: begin
                    if (pos_inc == grta_pkg::POS_STATUS) begin
                      if (b != grta_pkg::CH_A) active_d = 1'b0;
                    end else if (b == grta_pkg::CH_COMMA) begin
                      field_d = grta_pkg::FS_SKIP_FIRST;
                      pos_d   = '0;
                    end
                  end
                  // ddmmyy
                  grta_pkg::FS_DATE: begin
                    if (dig_pos_ok) begin
                      for (int i = 0; i < 3; i++) begin
                        if (dig_slot == 2'(i)) begin
                          td_d[grta_pkg::TD_DATE_BASE+i] = pos_inc[0] ? digit_x10 :
                              td_q[grta_pkg::TD_DATE_BASE+i] + digit;
                        end
                      end
                    end
                    if (pos_inc == grta_pkg::POS_DIG_LAST) begin
                      date_done = 1'b1;
                      active_d  = 1'b0;
                    end
                  end
                  default: begin
                    // Skipped fields advance on a comma; unused states close
                    if (field_q == grta_pkg::FS_SKIP_TIME ||
                        field_q inside {[grta_pkg::FS_SKIP_FIRST:grta_pkg::FS_SKIP_LAST]}) begin
                      if (b == grta_pkg::CH_COMMA) begin
                        field_d = (field_q == grta_pkg::FS_SKIP_TIME) ?
                                  grta_pkg::FS_STATUS : field_q + 1'b1;
                        pos_d   = '0;
                      end
                    end else begin
                      active_d = 1'b0;
                    end
                  end
                endcase
              end
            end else if (b_valid && b == grta_pkg::CH_DOLLAR) begin
              // Open a sentence
              field_d  = grta_pkg::FS_TYPE;
              pos_d    = '0;
              active_d = 1'b1;
            end
            if (date_done) begin
              state_d   = grta_pkg::ACQ_WAIT_PPS;
              elapsed_d = '0;
            end
          end
        end
        grta_pkg::ACQ_WAIT_PPS: begin
          pps_d = item_i.pps_level;
          if (!pps_q && item_i.pps_level) begin
            state_d   = grta_pkg::ACQ_AVAILABLE;
            elapsed_d = '0;
            enable_d  = 1'b0;
          end else if (elapsed_inc > {{(grta_pkg::MS_W-grta_pkg::WIN_W){1'b0}},
                                      cfg_i.pps_window_ms}) begin
            if (trial_next > {1'b0, cfg_i.pps_max_trials}) begin
              state_d   = grta_pkg::ACQ_AVAILABLE;
              elapsed_d = '0;
              enable_d  = 1'b0;
            end else begin
              trials_d  = trial_next[grta_pkg::TRIAL_W-1:0];
              state_d   = grta_pkg::ACQ_GET_TIME;
              elapsed_d = '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Commit the step
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= grta_pkg::ACQ_GET_TIME;
      elapsed_q <= '0;
      trials_q  <= '0;
      pps_q     <= 1'b0;
      active_q  <= 1'b0;
      rmc_q     <= 1'b0;
      field_q   <= grta_pkg::FS_TYPE;
      pos_q     <= '0;
      enable_q  <= 1'b0;
      for (int i = 0; i < grta_pkg::NUM_TD; i++) td_q[i] <= '0;
    end else if (step_i) begin
      state_q   <= state_d;
      elapsed_q <= elapsed_d;
      trials_q  <= trials_d;
      pps_q     <= pps_d;
      active_q  <= active_d;
      rmc_q     <= rmc_d;
      field_q   <= field_d;
      pos_q     <= pos_d;
      enable_q  <= enable_d;
      td_q      <= td_d;
    end
  end

  // Result of this step
  always_comb begin
    result_o.acq_status = state_d;
    result_o.rcv_enable = enable_d;
    result_o.hour       = td_d[0];
    result_o.minute     = td_d[1];
    result_o.second     = td_d[2];
    result_o.day        = td_d[3];
    result_o.month      = td_d[4];
    result_o.year       = grta_pkg::YEAR_BASE +
                          {{(grta_pkg::YEAR_W-grta_pkg::BYTE_W){1'b0}}, td_d[5]};
  end

endmodule

`default_nettype wire

### sv/gps_rmc_time_acquisition.sv
// GPS RMC time acquisition: takes one item per clock while not stalled (receiver byte,
// PPS level, ms tick, start command) and returns one status/time/date item for each.
// Each item goes from the input register through the parser/state step into the
// result register. The input stalls only while a result that is not taken is held
// in the result register and the input register is also full. There is no clearing
// pass after reset.
// Depends on grta_pkg, grta_chan_if, grta_cfg_regs and grta_core.
`default_nettype none

module gps_rmc_time_acquisition (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  grta_chan_if.sink   in_i,
  grta_chan_if.source out_o,
  grta_chan_if.sink   cfg_i
);

  grta_pkg::cfg_t     cfg;
  grta_pkg::in_item_t in_item_q;
  grta_pkg::result_t  step_result;
  grta_pkg::result_t  out_item_q;
  logic               in_valid_q, in_valid_d;
  logic               out_valid_q, out_valid_d;
  logic               advance;
  logic               step;

  grta_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  // Step when the result register is free or being emptied
  assign advance    = !out_valid_q || out_o.ready;
  assign step       = in_valid_q && advance;
  assign in_i.ready = !in_valid_q || advance;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_i.valid && in_i.ready) begin
      in_valid_d = 1'b1;
    end else if (step) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (step) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Capture the item and the result payloads
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) in_item_q <= in_i.payload;
    if (step) out_item_q <= step_result;
  end

  grta_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (in_item_q),
    .cfg_i    (cfg),
    .result_o (step_result)
  );

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_item_q;

endmodule

`default_nettype wire

### sv/grta_checker.sv
// Port-level checks for gps_rmc_time_acquisition, bound to the top level.
// Depends on grta_pkg.
`default_nettype none

module grta_checker (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input grta_pkg::result_t      out_item
);

  // Hold a stalled result item
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result item dropped or changed while stalled");

  // Input side never stalls while the result register is empty
  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  // Receiver is off once acquisition has finished
  a_enable_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && (out_item.acq_status == grta_pkg::ACQ_AVAILABLE ||
                  out_item.acq_status == grta_pkg::ACQ_NO_TIME)
    |-> !out_item.rcv_enable)
    else $error("receiver enabled after acquisition finished");

  // Year stays within the 8-bit offset window from YEAR_BASE to YEAR_LAST
  a_year_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> out_item.year >= grta_pkg::YEAR_BASE &&
                  out_item.year <= grta_pkg::YEAR_LAST)
    else $error("year out of range");

endmodule

bind gps_rmc_time_acquisition grta_checker u_grta_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_ready  (in_i.ready),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .out_item  (out_o.payload)
);

`default_nettype wire

### dv/tb_top.sv
// Self-checking testbench for gps_rmc_time_acquisition: NMEA RMC streams, PPS and
// ms ticks go in; every status/time item is checked against an in-bench predictor.
// Depends on grta_pkg, grta_chan_if and the RTL of the block.
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned MS_W      = grta_pkg::MS_W;
  localparam int unsigned WIN_W     = grta_pkg::WIN_W;
  localparam int unsigned TRIAL_W   = grta_pkg::TRIAL_W;
  localparam int unsigned FIELD_W   = grta_pkg::FIELD_W;
  localparam int unsigned POS_W     = grta_pkg::POS_W;
  localparam int unsigned BYTE_W    = grta_pkg::BYTE_W;
  localparam int unsigned YEAR_W    = grta_pkg::YEAR_W;
  localparam int unsigned CFG_IDX_W = grta_pkg::CFG_IDX_W;
  localparam int unsigned IN_W      = $bits(grta_pkg::in_item_t);

  // Sentence shapes produced by the stimulus
  typedef enum int unsigned {
    SENT_GOOD,
    SENT_WILD,
    SENT_BAD_TYPE,
    SENT_NO_SEP,
    SENT_VOID,
    SENT_CUT,
    SENT_LONG
  } sent_e;

  logic clk_i = 1'b0;
  logic rst_ni;

  grta_chan_if #(.payload_t(grta_pkg::in_item_t))   in_if ();
  grta_chan_if #(.payload_t(grta_pkg::result_t))    out_if ();
  grta_chan_if #(.payload_t(grta_pkg::cfg_write_t)) cfg_if ();

  gps_rmc_time_acquisition dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  always #6 clk_i = ~clk_i;

  // Stimulus and checking bookkeeping
  grta_pkg::in_item_t pending_q[$];
  grta_pkg::result_t  status_time_q[$];
  int unsigned n_items_queued = 0;
  int unsigned n_items_taken  = 0;
  int unsigned n_status_seen  = 0;
  int unsigned n_mismatch     = 0;
  logic        in_taken       = 1'b0;
  logic        no_idle        = 1'b0;

  // Predicted configuration
  logic [MS_W-1:0]    lim_ms;
  logic [WIN_W-1:0]   win_ms;
  logic [TRIAL_W-1:0] max_trials;

  // Predicted acquisition state
  grta_pkg::acq_state_e acq_st;
  logic [MS_W-1:0]    elapsed;
  logic [TRIAL_W-1:0] trials;
  logic               pps_prev;
  logic               pps_cur;
  logic               in_sentence;
  logic               type_ok;
  logic [FIELD_W-1:0] field_st;
  logic [POS_W-1:0]   pos;
  logic               date_done;
  logic               rcv_en;
  logic [BYTE_W-1:0]  td[grta_pkg::NUM_TD];

  function automatic logic rand_bit();
    return 1'($urandom_range(1));
  endfunction

  function automatic logic [BYTE_W-1:0] rand_byte();
    return BYTE_W'($urandom);
  endfunction

  function automatic void reset_acquisition();
    lim_ms      = grta_pkg::RST_TIME_LIMIT;
    win_ms      = grta_pkg::RST_PPS_WINDOW;
    max_trials  = grta_pkg::RST_PPS_TRIALS;
    acq_st      = grta_pkg::ACQ_GET_TIME;
    elapsed     = '0;
    trials      = '0;
    pps_prev    = 1'b0;
    pps_cur     = 1'b0;
    in_sentence = 1'b0;
    type_ok     = 1'b0;
    field_st    = grta_pkg::FS_TYPE;
    pos         = '0;
    date_done   = 1'b0;
    rcv_en      = 1'b0;
    foreach (td[i]) td[i] = '0;
  endfunction

  function automatic void apply_reg(grta_pkg::cfg_write_t wr);
    case (wr.index)
      grta_pkg::CFG_TIME_LIMIT: lim_ms = wr.value;
      grta_pkg::CFG_PPS_WINDOW: win_ms = wr.value[WIN_W-1:0];
      grta_pkg::CFG_PPS_TRIALS: max_trials = wr.value[TRIAL_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic void finish_acq(grta_pkg::acq_state_e st);
    acq_st  = st;
    elapsed = '0;
    rcv_en  = 1'b0;
  endfunction

  // Tens on odd positions, units added on even ones; all arithmetic wraps at 8 bits
  function automatic void place_digit(int unsigned base, logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] d;
    int unsigned       k;
    d = b - grta_pkg::CH_ZERO;
    if (pos < 8'd1 || pos > grta_pkg::POS_DIG_LAST) return;
    k = base + int'((pos - 8'd1) >> 1);
    if (pos[0]) td[k] = d * 8'd10;
    else td[k] = td[k] + d;
  endfunction

  function automatic void parse_char(logic [BYTE_W-1:0] b);
    if (pos != grta_pkg::POS_MAX) pos = pos + 8'd1;
    case (field_st)
      grta_pkg::FS_TYPE: begin
        if (pos == grta_pkg::POS_TYPE_R) begin
          type_ok = (b == grta_pkg::CH_R);
        end else if (pos == grta_pkg::POS_TYPE_M) begin
          type_ok = type_ok && (b == grta_pkg::CH_M);
        end else if (pos == grta_pkg::POS_TYPE_C) begin
          type_ok     = type_ok && (b == grta_pkg::CH_C);
          in_sentence = type_ok;
          if (type_ok) field_st = grta_pkg::FS_SEP;
        end
      end
      grta_pkg::FS_SEP: begin
        if (b == grta_pkg::CH_COMMA) begin
          field_st = grta_pkg::FS_TIME;
          pos      = '0;
        end else begin
          field_st    = grta_pkg::FS_TYPE;
          in_sentence = 1'b0;
        end
      end
      grta_pkg::FS_TIME: begin
        place_digit(grta_pkg::TD_TIME_BASE, b);
        if (pos == grta_pkg::POS_DIG_LAST) begin
          field_st = grta_pkg::FS_SKIP_TIME;
          pos      = '0;
        end
      end
      grta_pkg::FS_STATUS: begin
        if (pos == grta_pkg::POS_STATUS) begin
          if (b != grta_pkg::CH_A) begin
            date_done   = 1'b0;
            in_sentence = 1'b0;
          end
        end else if (b == grta_pkg::CH_COMMA) begin
          field_st = grta_pkg::FS_SKIP_FIRST;
          pos      = '0;
        end
      end
      grta_pkg::FS_DATE: begin
        place_digit(grta_pkg::TD_DATE_BASE, b);
        if (pos == grta_pkg::POS_DIG_LAST) begin
          date_done   = 1'b1;
          in_sentence = 1'b0;
        end
      end
      default: begin
        // Skip fields advance on a comma; anything else closes the sentence
        if (field_st == grta_pkg::FS_SKIP_TIME ||
            (field_st >= grta_pkg::FS_SKIP_FIRST && field_st <= grta_pkg::FS_SKIP_LAST)) begin
          if (b == grta_pkg::CH_COMMA) begin
            field_st = (field_st == grta_pkg::FS_SKIP_TIME) ? grta_pkg::FS_STATUS :
                       field_st + 4'd1;
            pos      = '0;
          end
        end else begin
          in_sentence = 1'b0;
        end
      end
    endcase
  endfunction

  // Advance the predicted block by one item and return its status/time item
  function automatic grta_pkg::result_t acquire_step(grta_pkg::in_item_t it);
    grta_pkg::result_t r;
    if (it.op) begin
      acq_st      = grta_pkg::ACQ_GET_TIME;
      in_sentence = 1'b0;
      rcv_en      = 1'b1;
      trials      = '0;
      elapsed     = '0;
    end else begin
      if (it.ms_tick && elapsed != grta_pkg::ELAPSED_MAX) elapsed = elapsed + 20'd1;
      case (acq_st)
        grta_pkg::ACQ_GET_TIME: begin
          if (elapsed > lim_ms) begin
            finish_acq(grta_pkg::ACQ_NO_TIME);
          end else begin
            if (in_sentence) begin
              if (it.byte_valid) parse_char(it.rx_byte);
            end else if (it.byte_valid && it.rx_byte == grta_pkg::CH_DOLLAR) begin
              field_st    = grta_pkg::FS_TYPE;
              pos         = '0;
              in_sentence = 1'b1;
            end
            if (date_done) begin
              acq_st    = grta_pkg::ACQ_WAIT_PPS;
              elapsed   = '0;
              date_done = 1'b0;
            end
          end
        end
        grta_pkg::ACQ_WAIT_PPS: begin
          pps_prev = pps_cur;
          pps_cur  = it.pps_level;
          if (!pps_prev && pps_cur) begin
            finish_acq(grta_pkg::ACQ_AVAILABLE);
          end else if (elapsed > {{(MS_W-WIN_W){1'b0}}, win_ms}) begin
            if ({1'b0, trials} + 5'd1 > {1'b0, max_trials}) begin
              finish_acq(grta_pkg::ACQ_AVAILABLE);
            end else begin
              trials  = trials + 4'd1;
              acq_st  = grta_pkg::ACQ_GET_TIME;
              elapsed = '0;
            end
          end
        end
        default: ;
      endcase
    end
    r.acq_status = acq_st;
    r.rcv_enable = rcv_en;
    r.hour       = td[0];
    r.minute     = td[1];
    r.second     = td[2];
    r.day        = td[3];
    r.month      = td[4];
    r.year       = grta_pkg::YEAR_BASE + {{(YEAR_W-BYTE_W){1'b0}}, td[5]};
    return r;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      n_mismatch++;
    end
  endfunction

  // Driver: present the next item at the falling edge, idle and stall at random unless no_idle is set
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_if.valid  <= 1'b0;
      out_if.ready <= 1'b0;
    end else begin
      if (!in_if.valid || in_taken) begin
        if (pending_q.size() != 0 && (no_idle || $urandom_range(99) >= 26)) begin
          in_if.valid   <= 1'b1;
          in_if.payload <= pending_q.pop_front();
        end else begin
          in_if.valid   <= 1'b0;
          in_if.payload <= grta_pkg::in_item_t'(IN_W'($urandom));
        end
      end
      out_if.ready <= no_idle || ($urandom_range(99) >= 26);
    end
  end

  // Monitor: predict on every accepted item, check every accepted result
  always @(posedge clk_i) begin : monitor
    grta_pkg::result_t want;
    in_taken <= rst_ni && in_if.valid && in_if.ready;
    if (rst_ni) begin
      if (cfg_if.valid && cfg_if.ready) apply_reg(cfg_if.payload);
      if (in_if.valid && in_if.ready) begin
        status_time_q.push_back(acquire_step(in_if.payload));
        n_items_taken++;
      end
      if (out_if.valid && out_if.ready) begin
        if (status_time_q.size() == 0) begin
          $display("%0t: result item with none expected, actual %p", $time,
                   out_if.payload);
          n_mismatch++;
        end else begin
          want = status_time_q.pop_front();
          n_status_seen++;
          check_field("acq_status", want.acq_status, out_if.payload.acq_status);
          check_field("rcv_enable", want.rcv_enable, out_if.payload.rcv_enable);
          check_field("hour", want.hour, out_if.payload.hour);
          check_field("minute", want.minute, out_if.payload.minute);
          check_field("second", want.second, out_if.payload.second);
          check_field("day", want.day, out_if.payload.day);
          check_field("month", want.month, out_if.payload.month);
          check_field("year", want.year, out_if.payload.year);
        end
      end
    end
  end

  task automatic queue_item(logic op, logic bv, logic [BYTE_W-1:0] b, logic pps, logic tick);
    grta_pkg::in_item_t it;
    it.op         = op;
    it.byte_valid = bv;
    it.rx_byte    = b;
    it.pps_level  = pps;
    it.ms_tick    = tick;
    pending_q.push_back(it);
    n_items_queued++;
  endtask

  // Send one received character, sometimes after an empty poll
  task automatic queue_char(logic [BYTE_W-1:0] b, int unsigned tick_pct);
    if ($urandom_range(99) < 15)
      queue_item(1'b0, 1'b0, rand_byte(), rand_bit(), $urandom_range(99) < tick_pct);
    queue_item(1'b0, 1'b1, b, rand_bit(), $urandom_range(99) < tick_pct);
  endtask

  task automatic queue_text(string txt);
    for (int i = 0; i < txt.len(); i++) queue_char(txt[i], 0);
  endtask

  function automatic logic [BYTE_W-1:0] pick_digit(logic wild);
    if (wild && $urandom_range(2) == 0) return rand_byte();
    return BYTE_W'("0" + $urandom_range(9));
  endfunction

  // Build one RMC sentence, well formed or broken as asked
  task automatic queue_rmc(sent_e kind, int unsigned tick_pct);
    logic [BYTE_W-1:0] s[$];
    int unsigned       cut;
    s.push_back(grta_pkg::CH_DOLLAR);
    repeat (2) s.push_back(BYTE_W'("A" + $urandom_range(25)));
    s.push_back(grta_pkg::CH_R);
    s.push_back(grta_pkg::CH_M);
    s.push_back(grta_pkg::CH_C);
    if (kind == SENT_BAD_TYPE) s[3 + $urandom_range(2)] = BYTE_W'("A" + $urandom_range(25));
    s.push_back(kind == SENT_NO_SEP ? "." : grta_pkg::CH_COMMA);
    repeat (6) s.push_back(pick_digit(kind == SENT_WILD));
    if ($urandom_range(1)) begin
      s.push_back(".");
      s.push_back("0");
      s.push_back("0");
    end
    s.push_back(grta_pkg::CH_COMMA);
    if (kind == SENT_VOID) s.push_back($urandom_range(1) ? "V" : grta_pkg::CH_COMMA);
    else s.push_back(grta_pkg::CH_A);
    // A status field long enough to saturate the byte position
    if (kind == SENT_LONG) repeat (300) s.push_back(BYTE_W'("0" + $urandom_range(9)));
    s.push_back(grta_pkg::CH_COMMA);
    repeat (6) begin
      repeat ($urandom_range(2)) s.push_back(BYTE_W'("0" + $urandom_range(9)));
      s.push_back(grta_pkg::CH_COMMA);
    end
    repeat (6) s.push_back(pick_digit(kind == SENT_WILD));
    if ($urandom_range(1)) begin
      s.push_back("*");
      s.push_back("4");
      s.push_back("7");
    end
    if (kind == SENT_CUT) begin
      cut = $urandom_range(s.size() - 1, 1);
      while (s.size() > cut) void'(s.pop_back());
    end
    foreach (s[i]) queue_char(s[i], tick_pct);
  endtask

  // Poll with a PPS pattern: clean rising edge, random toggling, or held high
  task automatic queue_pps(int unsigned tick_pct);
    int unsigned n, rise, mode;
    n    = $urandom_range(12, 2);
    rise = $urandom_range(n - 1);
    mode = $urandom_range(2);
    for (int i = 0; i < n; i++)
      queue_item(1'b0, $urandom_range(9) == 0, rand_byte(),
                 (mode == 0) ? (i >= rise) : (mode == 1) ? rand_bit() : 1'b1,
                 $urandom_range(99) < tick_pct);
  endtask

  task automatic queue_random(int unsigned count);
    int unsigned stop_at, r, tick_pct;
    stop_at = n_items_queued + count;
    while (n_items_queued < stop_at) begin
      r        = $urandom_range(99);
      tick_pct = ($urandom_range(2) == 0) ? 0 : ($urandom_range(1) ? 3 : 12);
      if (r < 12) begin
        queue_item(1'b1, rand_bit(), rand_byte(), rand_bit(), rand_bit());
      end else if (r < 50) begin
        queue_rmc($urandom_range(3) == 0 ? SENT_WILD : SENT_GOOD, tick_pct);
      end else if (r < 62) begin
        queue_rmc(sent_e'(SENT_BAD_TYPE + $urandom_range(3)), tick_pct);
      end else if (r < 82) begin
        queue_pps($urandom_range(1) ? 30 : 5);
      end else if (r < 92) begin
        repeat ($urandom_range(4, 1))
          queue_item(1'b0, rand_bit(),
                     ($urandom_range(9) == 0) ? grta_pkg::CH_DOLLAR : rand_byte(),
                     rand_bit(), $urandom_range(99) < 20);
      end else begin
        repeat ($urandom_range(8, 1))
          queue_item(1'b0, 1'b0, rand_byte(), rand_bit(), $urandom_range(99) < 80);
      end
    end
  endtask

  // Hold until every queued item is taken and every result has come back
  task automatic wait_drained();
    do @(negedge clk_i);
    while (n_items_taken != n_items_queued || n_status_seen != n_items_taken);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [MS_W-1:0] value);
    @(negedge clk_i);
    cfg_if.valid         <= 1'b1;
    cfg_if.payload.index <= idx;
    cfg_if.payload.value <= value;
    do @(posedge clk_i);
    while (!cfg_if.ready);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic run_setting(logic [MS_W-1:0] lim, logic [WIN_W-1:0] win,
                             logic [TRIAL_W-1:0] tr, int unsigned count);
    wait_drained();
    write_reg(grta_pkg::CFG_TIME_LIMIT, lim);
    write_reg(grta_pkg::CFG_PPS_WINDOW, MS_W'(win));
    write_reg(grta_pkg::CFG_PPS_TRIALS, MS_W'(tr));
    queue_random(count);
  endtask

  initial begin
    cfg_if.valid   = 1'b0;
    cfg_if.payload = '0;
    rst_ni         = 1'b0;
    reset_acquisition();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: start ignores its other fields, stray bytes are dropped,
    // digits wrap for non-digit characters, PPS edge makes time available
    queue_item(1'b1, 1'b1, 8'hFF, 1'b1, 1'b1);
    queue_item(1'b0, 1'b1, 8'h00, 1'b0, 1'b0);
    queue_item(1'b0, 1'b0, grta_pkg::CH_DOLLAR, 1'b0, 1'b1);
    queue_text("$GPRMC,");
    queue_char(8'h00, 0);
    queue_text("35959,A,,,,,,,31129");
    queue_char(8'hFF, 0);
    queue_item(1'b0, 1'b0, 8'h00, 1'b0, 1'b0);
    queue_item(1'b0, 1'b0, 8'h00, 1'b1, 1'b0);
    queue_item(1'b0, 1'b1, grta_pkg::CH_DOLLAR, 1'b0, 1'b0);

    // Random phases over several register settings, extremes included
    queue_random(65);
    run_setting(20'd30, 16'd3, 4'd2, 65);
    run_setting(20'd0, 16'd1, 4'd0, 65);
    wait_drained();
    no_idle = 1'b1;
    run_setting(grta_pkg::ELAPSED_MAX, 16'hFFFF, 4'd15, 0);
    queue_item(1'b1, 1'b0, 8'h00, 1'b0, 1'b0);
    queue_rmc(SENT_LONG, 0);
    queue_random(65);
    wait_drained();
    no_idle = 1'b0;
    run_setting(20'd60, 16'd2, 4'd1, 65);

    wait_drained();
    repeat (20) @(negedge clk_i);
    if (status_time_q.size() != 0) begin
      $display("%0t: %0d expected result items never arrived", $time, status_time_q.size());
      n_mismatch++;
    end
    if (n_mismatch == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #6000000;
    $display("tb_top failed");
    $finish;
  end

endmodule
